### sv/bfp_pkg.sv
// Shared types and constants for the binary frame parser.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package bfp_pkg;

    localparam int NUM_TYPES  = 5;
    localparam int SLOT_W     = 3;
    localparam int ADDR_W     = 5;
    localparam int DATA_W     = 32;

    localparam logic [7:0]  SYNC_BYTE = 8'h55;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    typedef logic [15:0] type_word_t;
    typedef type_word_t [NUM_TYPES-1:0] type_table_t;

    localparam type_table_t TYPE_RESET = {16'hFFFF, 16'd526, 16'd520, 16'd522, 16'd258};

    typedef enum logic [1:0] {
        EV_PAYLOAD  = 2'd0,
        EV_GOOD     = 2'd1,
        EV_CRC_ERR  = 2'd2,
        EV_UNKNOWN  = 2'd3
    } event_t;

    typedef enum logic [8:0] {
        PH_HUNT    = 9'b0_0000_0001,
        PH_TYPE_LO = 9'b0_0000_0010,
        PH_TYPE_HI = 9'b0_0000_0100,
        PH_SND_LO  = 9'b0_0000_1000,
        PH_SND_HI  = 9'b0_0001_0000,
        PH_LEN     = 9'b0_0010_0000,
        PH_PAYLOAD = 9'b0_0100_0000,
        PH_CRC_LO  = 9'b0_1000_0000,
        PH_CRC_HI  = 9'b1_0000_0000
    } phase_t;

    // Accepted message types, as seen by the parser.
    typedef struct packed {
        type_table_t accepted;
    } cfg_t;

endpackage
`default_nettype wire

### sv/bfp_cfg_regs.sv
// APB-style register file holding the five accepted message types.
// Depends on bfp_pkg.
`default_nettype none
module bfp_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bfp_pkg::DATA_W-1:0] pwdata,
    output logic      [bfp_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output bfp_pkg::cfg_t                   cfg
);
    import bfp_pkg::*;

    type_table_t types_reg;
    logic [ADDR_W-3:0] reg_idx;
    logic              wr_en;

    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            types_reg <= TYPE_RESET;
        end
        else if (wr_en && (reg_idx < (ADDR_W-2)'(NUM_TYPES)))
        begin
            types_reg[reg_idx] <= pwdata[15:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx < (ADDR_W-2)'(NUM_TYPES))
        begin
            prdata = {{(DATA_W-16){1'b0}}, types_reg[reg_idx]};
        end
    end

    assign cfg.accepted = types_reg;

endmodule
`default_nettype wire

### sv/bfp_crc16.sv
// One-byte update of a CRC-16/XMODEM remainder (poly 0x1021, MSB first).
// Depends on bfp_pkg.
`default_nettype none
module bfp_crc16 (
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data_in,
    output logic      [15:0] crc_out
);
    import bfp_pkg::*;

    always_comb
    begin
        logic [15:0] c;
        c = crc_in ^ {data_in, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        crc_out = c;
    end

endmodule
`default_nettype wire

### sv/bfp_parser.sv
// Frame state machine, header capture, type match and result register.
// Depends on bfp_pkg and bfp_crc16.
`default_nettype none
module bfp_parser (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  bfp_pkg::cfg_t      cfg,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic [7:0]    rx_byte,
    output logic               out_valid,
    input  wire logic          out_stall,
    output logic [1:0]         event_res,
    output logic [2:0]         type_slot,
    output logic [15:0]        frame_type,
    output logic [15:0]        frame_sender,
    output logic [7:0]         frame_length,
    output logic [7:0]         byte_index,
    output logic [7:0]         byte_value
);
    import bfp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [15:0]       type_reg, type_next;
    logic [15:0]       sender_reg, sender_next;
    logic [7:0]        length_reg, length_next;
    logic [7:0]        count_reg, count_next;
    logic [15:0]       crc_reg, crc_next;
    logic [7:0]        crc_lo_reg, crc_lo_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              out_valid_reg;
    event_t            event_reg, event_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic [15:0]       otype_reg;
    logic [15:0]       osender_reg;
    logic [7:0]        olength_reg;
    logic [7:0]        oindex_reg, oindex_next;
    logic [7:0]        ovalue_reg, ovalue_next;

    logic [15:0]       crc_fed;
    logic              emit;
    logic              accept;
    logic              hit;
    logic [SLOT_W-1:0] hit_slot;

    bfp_crc16 u_crc (
        .crc_in  (crc_reg),
        .data_in (rx_byte),
        .crc_out (crc_fed)
    );

    // A request may produce a result, so hold input while the result slot is blocked.
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Lowest-numbered matching type wins.
    always_comb
    begin
        hit      = 1'b0;
        hit_slot = '0;
        for (int i = NUM_TYPES - 1; i >= 0; i--)
        begin
            if (cfg.accepted[i] == type_reg)
            begin
                hit      = 1'b1;
                hit_slot = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        sender_next = sender_reg;
        length_next = length_reg;
        count_next  = count_reg;
        crc_next    = crc_reg;
        crc_lo_next = crc_lo_reg;
        slot_next   = slot_reg;
        emit        = 1'b0;
        event_next  = EV_PAYLOAD;
        oslot_next  = '0;
        oindex_next = '0;
        ovalue_next = '0;
        unique case (phase_reg)
            PH_TYPE_LO:
            begin
                type_next  = {8'h00, rx_byte};
                crc_next   = crc_fed;
                phase_next = PH_TYPE_HI;
            end
            PH_TYPE_HI:
            begin
                type_next  = {rx_byte, type_reg[7:0]};
                crc_next   = crc_fed;
                phase_next = PH_SND_LO;
            end
            PH_SND_LO:
            begin
                sender_next = {8'h00, rx_byte};
                crc_next    = crc_fed;
                phase_next  = PH_SND_HI;
            end
            PH_SND_HI:
            begin
                sender_next = {rx_byte, sender_reg[7:0]};
                crc_next    = crc_fed;
                phase_next  = PH_LEN;
            end
            PH_LEN:
            begin
                length_next = rx_byte;
                crc_next    = crc_fed;
                count_next  = '0;
                if (hit)
                begin
                    slot_next  = hit_slot;
                    phase_next = (rx_byte == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
                end
                else
                begin
                    // Unknown type: flag once and resync.
                    emit       = 1'b1;
                    event_next = EV_UNKNOWN;
                    phase_next = PH_HUNT;
                end
            end
            PH_PAYLOAD:
            begin
                crc_next    = crc_fed;
                emit        = 1'b1;
                event_next  = EV_PAYLOAD;
                oslot_next  = slot_reg;
                oindex_next = count_reg;
                ovalue_next = rx_byte;
                count_next  = count_reg + 8'd1;
                if (count_next == length_reg)
                    phase_next = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                crc_lo_next = rx_byte;
                phase_next  = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                emit       = 1'b1;
                event_next = ({rx_byte, crc_lo_reg} == crc_reg) ? EV_GOOD : EV_CRC_ERR;
                oslot_next = slot_reg;
                phase_next = PH_HUNT;
            end
            default:
            begin
                // Hunting, or an unused code: drop everything but the preamble.
                phase_next = PH_HUNT;
                if (rx_byte == SYNC_BYTE)
                begin
                    type_next   = '0;
                    sender_next = '0;
                    length_next = '0;
                    count_next  = '0;
                    crc_next    = '0;
                    phase_next  = PH_TYPE_LO;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            type_reg   <= '0;
            sender_reg <= '0;
            length_reg <= '0;
            count_reg  <= '0;
            crc_reg    <= '0;
            crc_lo_reg <= '0;
            slot_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            sender_reg <= sender_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
            slot_reg   <= slot_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && emit)
            out_valid_reg <= 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            event_reg   <= event_next;
            oslot_reg   <= oslot_next;
            otype_reg   <= type_next;
            osender_reg <= sender_next;
            olength_reg <= length_next;
            oindex_reg  <= oindex_next;
            ovalue_reg  <= ovalue_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_res    = event_reg;
    assign type_slot    = oslot_reg;
    assign frame_type   = otype_reg;
    assign frame_sender = osender_reg;
    assign frame_length = olength_reg;
    assign byte_index   = oindex_reg;
    assign byte_value   = ovalue_reg;

endmodule
`default_nettype wire

### sv/binary_frame_parser_crc16.sv
// Top level of the binary frame parser with CRC-16/XMODEM check.
// Depends on bfp_pkg, bfp_cfg_regs and bfp_parser.
//
// One received byte is taken per cycle unless stalled: the frame state machine,
// the type match and the one-byte CRC update all finish in the cycle the byte is
// taken, and a result register sits between the parser and the output channel.
// A frame is 0x55, type (2 bytes LE), sender (2 bytes LE), length, payload, CRC
// (2 bytes LE). Each payload byte comes out as event 0 with its index; the CRC
// bytes yield event 1 (good) or 2 (CRC error, drop the payload); a type that
// matches none of the five accepted-type registers yields event 3 at the length
// byte and the parser resyncs. Registers sit at byte addresses 0, 4, 8, 12, 16
// and should be written only while no frame is in flight.
`default_nettype none
module binary_frame_parser_crc16 (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [bfp_pkg::ADDR_W-1:0] paddr,
    input  wire logic [bfp_pkg::DATA_W-1:0] pwdata,
    output logic      [bfp_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic [7:0]                 rx_byte,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic [1:0]                      event_res,
    output logic [2:0]                      type_slot,
    output logic [15:0]                     frame_type,
    output logic [15:0]                     frame_sender,
    output logic [7:0]                      frame_length,
    output logic [7:0]                      byte_index,
    output logic [7:0]                      byte_value
);
    import bfp_pkg::*;

    cfg_t cfg;

    bfp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bfp_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .type_slot    (type_slot),
        .frame_type   (frame_type),
        .frame_sender (frame_sender),
        .frame_length (frame_length),
        .byte_index   (byte_index),
        .byte_value   (byte_value)
    );

endmodule
`default_nettype wire

### tb/binary_frame_parser_crc16_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for binary_frame_parser_crc16: byte stream in, parser events out.
// Depends on bfp_pkg and the parser RTL; expected events come from a local frame tracker.
module binary_frame_parser_crc16_tb;
    import bfp_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int REG_STRIDE     = 4;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int WHOLE          = 1 << 16;

    typedef struct packed {
        event_t      ev;
        logic [2:0]  slot;
        logic [15:0] ftype;
        logic [15:0] sender;
        logic [7:0]  len;
        logic [7:0]  idx;
        logic [7:0]  value;
    } parser_event_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    logic [7:0]        rx_byte   = 8'h00;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [1:0]        event_res;
    logic [2:0]        type_slot;
    logic [15:0]       frame_type;
    logic [15:0]       frame_sender;
    logic [7:0]        frame_length;
    logic [7:0]        byte_index;
    logic [7:0]        byte_value;

    binary_frame_parser_crc16 dut (.*);

    always #1 clk = ~clk;

    // Frame tracker state and its copy of the accepted-type registers
    type_word_t  accept_types [NUM_TYPES];
    phase_t      trk_phase;
    logic [15:0] trk_type;
    logic [15:0] trk_sender;
    logic [7:0]  trk_len;
    logic [7:0]  trk_count;
    logic [15:0] trk_crc;
    logic [7:0]  trk_crc_lo;
    logic [2:0]  trk_slot;

    logic [7:0]    rx_bytes_todo [$];
    parser_event_t parser_events_due [$];
    parser_event_t next_due;
    int            stim_bytes    = 0;
    int            error_count   = 0;
    int            send_idle_pct = 0;
    int            recv_idle_pct = 0;
    int            quiet_cycles  = 0;

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int k;
        c = crc ^ {b, 8'h00};
        for (k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // Lowest register holding the type wins; -1 when none does
    function automatic int match_slot(input logic [15:0] t);
        int i;
        for (i = NUM_TYPES - 1; i >= 0; i--)
            if (accept_types[i] == t)
                match_slot = i;
        for (i = 0; i < NUM_TYPES; i++)
            if (accept_types[i] == t)
                return i;
        return -1;
    endfunction

    function automatic void push_event(input event_t ev, input logic [2:0] slot,
                                       input logic [7:0] idx, input logic [7:0] value);
        parser_event_t e;
        e.ev     = ev;
        e.slot   = slot;
        e.ftype  = trk_type;
        e.sender = trk_sender;
        e.len    = trk_len;
        e.idx    = idx;
        e.value  = value;
        parser_events_due.push_back(e);
    endfunction

    function automatic void track_frame_byte(input logic [7:0] b);
        int slot;
        case (trk_phase)
            PH_TYPE_LO:
            begin
                trk_type  = {8'h00, b};
                trk_crc   = crc16_step(trk_crc, b);
                trk_phase = PH_TYPE_HI;
            end
            PH_TYPE_HI:
            begin
                trk_type[15:8] = b;
                trk_crc        = crc16_step(trk_crc, b);
                trk_phase      = PH_SND_LO;
            end
            PH_SND_LO:
            begin
                trk_sender = {8'h00, b};
                trk_crc    = crc16_step(trk_crc, b);
                trk_phase  = PH_SND_HI;
            end
            PH_SND_HI:
            begin
                trk_sender[15:8] = b;
                trk_crc          = crc16_step(trk_crc, b);
                trk_phase        = PH_LEN;
            end
            PH_LEN:
            begin
                trk_len   = b;
                trk_crc   = crc16_step(trk_crc, b);
                trk_count = 8'h00;
                slot      = match_slot(trk_type);
                if (slot < 0) begin
                    // unknown type: report once and resync
                    trk_phase = PH_HUNT;
                    push_event(EV_UNKNOWN, 3'd0, 8'h00, 8'h00);
                end
                else begin
                    trk_slot  = 3'(slot);
                    trk_phase = (trk_len == 8'h00) ? PH_CRC_LO : PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                trk_crc = crc16_step(trk_crc, b);
                push_event(EV_PAYLOAD, trk_slot, trk_count, b);
                trk_count = trk_count + 8'h01;
                if (trk_count == trk_len)
                    trk_phase = PH_CRC_LO;
            end
            PH_CRC_LO:
            begin
                trk_crc_lo = b;
                trk_phase  = PH_CRC_HI;
            end
            PH_CRC_HI:
            begin
                trk_phase = PH_HUNT;
                push_event(({b, trk_crc_lo} == trk_crc) ? EV_GOOD : EV_CRC_ERR,
                           trk_slot, 8'h00, 8'h00);
            end
            default:
            begin
                trk_phase = PH_HUNT;
                if (b == SYNC_BYTE) begin
                    trk_type   = 16'h0000;
                    trk_sender = 16'h0000;
                    trk_len    = 8'h00;
                    trk_count  = 8'h00;
                    trk_crc    = 16'h0000;
                    trk_phase  = PH_TYPE_LO;
                end
            end
        endcase
    endfunction

    // Build one frame and queue its first `keep` bytes; unknown types get a header only
    task automatic queue_frame(input logic [15:0] ftype, input logic [15:0] sender,
                               input logic [7:0] len, input bit bad_crc, input int keep);
        logic [7:0]  frame [$];
        logic [47:0] hdr;
        logic [15:0] crc;
        logic [7:0]  b;
        int k;
        hdr = {len, sender, ftype, SYNC_BYTE};
        crc = 16'h0000;
        for (k = 0; k < 6; k++) begin
            frame.push_back(hdr[8*k +: 8]);
            if (k > 0)
                crc = crc16_step(crc, hdr[8*k +: 8]);
        end
        if (match_slot(ftype) >= 0) begin
            for (k = 0; k < len; k++) begin
                b = 8'($urandom);
                frame.push_back(b);
                crc = crc16_step(crc, b);
            end
            if (bad_crc)
                crc = crc ^ 16'($urandom_range(1, 65535));
            frame.push_back(crc[7:0]);
            frame.push_back(crc[15:8]);
        end
        for (k = 0; k < frame.size() && k < keep; k++) begin
            rx_bytes_todo.push_back(frame[k]);
            stim_bytes++;
        end
    endtask

    // Mostly well-formed frames, plus noise, unknown types, bad CRCs and cut frames
    task automatic queue_traffic(input int budget);
        int start;
        int kind;
        int n;
        int k;
        logic [15:0] t;
        logic [7:0]  len;
        start = stim_bytes;
        while (stim_bytes - start < budget) begin
            kind = $urandom_range(99);
            len  = ($urandom_range(99) < 85) ? 8'($urandom_range(15))
                                             : 8'($urandom_range(16, 80));
            t    = accept_types[$urandom_range(NUM_TYPES - 1)];
            if (kind < 8) begin
                n = $urandom_range(1, 3);
                for (k = 0; k < n; k++)
                    rx_bytes_todo.push_back(8'($urandom));
            end
            else if (kind < 20)
                queue_frame(16'($urandom), 16'($urandom), len, 1'b0, WHOLE);
            else if (kind < 26)
                queue_frame(t, 16'($urandom), len, 1'b0, $urandom_range(1, 7 + len));
            else
                queue_frame(t, 16'($urandom), len, $urandom_range(99) < 15, WHOLE);
        end
    endtask

    task automatic write_types(input type_table_t tbl);
        int i;
        for (i = 0; i < NUM_TYPES; i++) begin
            @(posedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'(REG_STRIDE * i);
            pwdata  <= DATA_W'(tbl[i]);
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            accept_types[i] = tbl[i];
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (rx_bytes_todo.size() != 0 || in_valid || parser_events_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    // Request driver: hold a stalled request, otherwise load the next byte or idle
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            rx_byte  <= 8'h00;
        end
        else begin
            if (in_valid && !in_stall)
                track_frame_byte(rx_byte);
            if (!in_valid || !in_stall) begin
                if (rx_bytes_todo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    rx_byte  <= rx_bytes_todo.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Event monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            out_stall <= 1'b0;
        else begin
            if (out_valid && !out_stall) begin
                if (parser_events_due.size() == 0) begin
                    $display("%0t: unexpected event, expected none, actual event %0d type %h",
                             $time, event_res, frame_type);
                    error_count++;
                end
                else begin
                    next_due = parser_events_due.pop_front();
                    check_field("event_res", 16'(next_due.ev), 16'(event_res));
                    check_field("type_slot", 16'(next_due.slot), 16'(type_slot));
                    check_field("frame_type", next_due.ftype, frame_type);
                    check_field("frame_sender", next_due.sender, frame_sender);
                    check_field("frame_length", 16'(next_due.len), 16'(frame_length));
                    check_field("byte_index", 16'(next_due.idx), 16'(byte_index));
                    check_field("byte_value", 16'(next_due.value), 16'(byte_value));
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL binary_frame_parser_crc16");
                $finish;
            end
        end
    end

    initial begin
        type_table_t tbl;
        int i;
        for (i = 0; i < NUM_TYPES; i++)
            accept_types[i] = TYPE_RESET[i];
        trk_phase     = PH_HUNT;
        trk_type      = 16'h0000;
        trk_sender    = 16'h0000;
        trk_len       = 8'h00;
        trk_count     = 8'h00;
        trk_crc       = 16'h0000;
        trk_crc_lo    = 8'h00;
        trk_slot      = 3'd0;
        send_idle_pct = 32;
        recv_idle_pct = 53;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: ignored byte while hunting, heartbeat with empty payload,
        // payload frame with a bad CRC, unknown type with the longest length
        rx_bytes_todo.push_back(8'h00);
        queue_frame(16'hFFFF, 16'h0000, 8'd0, 1'b0, WHOLE);
        queue_frame(TYPE_RESET[0], 16'hFFFF, 8'd2, 1'b1, WHOLE);
        queue_frame(16'h0000, 16'h1234, 8'hFF, 1'b0, WHOLE);
        wait_idle();

        // Extremes, with a duplicate so the lower slot must win
        write_types({16'h7FFE, 16'h8001, 16'h0000, 16'hFFFF, 16'h0000});
        queue_traffic(500);
        wait_idle();

        send_idle_pct = 53;
        recv_idle_pct = 32;
        for (i = 0; i < NUM_TYPES; i++)
            tbl[i] = 16'($urandom);
        write_types(tbl);
        queue_traffic(500);
        wait_idle();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_types(TYPE_RESET);
        queue_frame(TYPE_RESET[NUM_TYPES - 1], 16'($urandom), 8'hFF, 1'b0, WHOLE);
        queue_traffic(300);
        wait_idle();
        repeat (TAIL_CYCLES) @(negedge clk);

        if (error_count == 0 && parser_events_due.size() == 0)
            $display("PASS binary_frame_parser_crc16");
        else
            $display("FAIL binary_frame_parser_crc16");
        $finish;
    end

endmodule

### filelist.f
sv/bfp_pkg.sv
sv/bfp_cfg_regs.sv
sv/bfp_crc16.sv
sv/bfp_parser.sv
sv/binary_frame_parser_crc16.sv
tb/binary_frame_parser_crc16_tb.sv
